/* hw/rtl/atm_pkg.sv */
// shared types and constants for the affine triangle mapping unit
`timescale 1ns / 1ps
package atm_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int FRAC_W  = 16;
	localparam int NUM_W   = SUM_W + FRAC_W;
	localparam int QUO_W   = COORD_W;
	localparam int CMP_W   = SUM_W + QUO_W;
	localparam int NREGS   = 6;
	localparam int IDX_W   = 3;

	localparam logic [COORD_W-1:0] ONE_Q16  = 32'h0001_0000;
	localparam logic [COORD_W-1:0] POS_MAX  = 32'h7fff_ffff;
	localparam logic [COORD_W-1:0] NEG_MIN  = 32'h8000_0000;

	// register indexes
	localparam logic [IDX_W-1:0] REG_V0X = 3'd0;
	localparam logic [IDX_W-1:0] REG_V0Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_V1X = 3'd2;
	localparam logic [IDX_W-1:0] REG_V1Y = 3'd3;
	localparam logic [IDX_W-1:0] REG_V2X = 3'd4;
	localparam logic [IDX_W-1:0] REG_V2Y = 3'd5;

	localparam logic MODE_FWD = 1'b0;
	localparam logic MODE_INV = 1'b1;

	typedef struct packed {
		logic                      mode;
		logic signed [COORD_W-1:0] point_a;
		logic signed [COORD_W-1:0] point_b;
	} atm_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] mapped_a;
		logic signed [COORD_W-1:0] mapped_b;
		logic                      inside_reference;
		logic                      degenerate;
		logic                      saturated;
	} atm_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] v0x;
		logic signed [COORD_W-1:0] v0y;
		logic signed [COORD_W-1:0] v1x;
		logic signed [COORD_W-1:0] v1y;
		logic signed [COORD_W-1:0] v2x;
		logic signed [COORD_W-1:0] v2y;
	} atm_vtx_t;

	// side information carried alongside the divider
	typedef struct packed {
		logic               mode;
		logic               degen;
		logic               neg_a;
		logic               neg_b;
		logic [COORD_W-1:0] fwd_a;
		logic [COORD_W-1:0] fwd_b;
		logic               fwd_sat;
		logic               fwd_inside;
	} atm_side_t;

	typedef struct packed {
		atm_side_t          side;
		logic [NUM_W-1:0]   num_a;
		logic [NUM_W-1:0]   num_b;
		logic [SUM_W-1:0]   den;
	} atm_front_t;

	// inside or on the unit reference triangle
	function automatic logic in_ref(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] s);
		logic signed [COORD_W+1:0] rr;
		logic signed [COORD_W+1:0] ss;
		logic signed [COORD_W+1:0] one;
		rr  = $signed({{2{r[COORD_W-1]}}, r});
		ss  = $signed({{2{s[COORD_W-1]}}, s});
		one = $signed({2'b00, ONE_Q16});
		return !rr[COORD_W+1] && (rr <= one) && !ss[COORD_W+1] && (ss <= one - rr);
	endfunction

endpackage

/* hw/rtl/atm_front.sv */
// front pipeline: vertex differences, products, sums, magnitudes and forward results
`timescale 1ns / 1ps
module atm_front import atm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_vld,
	input  atm_in_t    in_item,
	input  atm_vtx_t   vtx,
	output logic       out_vld,
	output atm_front_t out_data
);

	// stage 1 operands
	logic                     v_s1, mode_s1, inside_s1;
	logic signed [DIFF_W-1:0] k0_s1, k2_s1, a11_s1, a12_s1, a21_s1, a22_s1, u_s1, w_s1;
	logic signed [COORD_W-1:0] v0x_s1, v0y_s1;
	// stage 2 products
	logic                     v_s2, mode_s2, inside_s2;
	logic signed [PROD_W-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [COORD_W-1:0] v0x_s2, v0y_s2;
	// stage 3 sums
	logic                     v_s3, mode_s3, inside_s3;
	logic signed [SUM_W-1:0]  sx_s3, sy_s3, det_s3;

	logic signed [DIFF_W-1:0] a11, a12, a21, a22, dx, dy, pa, pb;

	always_comb begin
		pa  = DIFF_W'(in_item.point_a);
		pb  = DIFF_W'(in_item.point_b);
		a11 = DIFF_W'(vtx.v1x) - DIFF_W'(vtx.v0x);
		a21 = DIFF_W'(vtx.v1y) - DIFF_W'(vtx.v0y);
		a12 = DIFF_W'(vtx.v2x) - DIFF_W'(vtx.v0x);
		a22 = DIFF_W'(vtx.v2y) - DIFF_W'(vtx.v0y);
		dx  = pa - DIFF_W'(vtx.v0x);
		dy  = pb - DIFF_W'(vtx.v0y);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_vld <= v_s3;
		end
	end

	// stage 1: differences and operand selection per mode
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= in_item.mode;
			inside_s1 <= in_ref(in_item.point_a, in_item.point_b);
			k0_s1     <= (in_item.mode == MODE_FWD) ? a11 : a22;
			k2_s1     <= (in_item.mode == MODE_FWD) ? a22 : a11;
			a11_s1    <= a11;
			a12_s1    <= a12;
			a21_s1    <= a21;
			a22_s1    <= a22;
			u_s1      <= (in_item.mode == MODE_FWD) ? pa : dx;
			w_s1      <= (in_item.mode == MODE_FWD) ? pb : dy;
			v0x_s1    <= vtx.v0x;
			v0y_s1    <= vtx.v0y;
		end
	end

	// stage 2: six exact products
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2   <= mode_s1;
			inside_s2 <= inside_s1;
			m0_s2     <= k0_s1 * u_s1;
			m1_s2     <= a12_s1 * w_s1;
			m2_s2     <= k2_s1 * w_s1;
			m3_s2     <= a21_s1 * u_s1;
			m4_s2     <= a11_s1 * a22_s1;
			m5_s2     <= a21_s1 * a12_s1;
			v0x_s2    <= v0x_s1;
			v0y_s2    <= v0y_s1;
		end
	end

	// stage 3: mapped sums, numerators and determinant
	logic signed [SUM_W-1:0] bx, by;
	assign bx = SUM_W'(v0x_s2) <<< FRAC_W;
	assign by = SUM_W'(v0y_s2) <<< FRAC_W;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3   <= mode_s2;
			inside_s3 <= inside_s2;
			if (mode_s2 == MODE_FWD) begin
				sx_s3 <= SUM_W'(m0_s2) + SUM_W'(m1_s2) + bx;
				sy_s3 <= SUM_W'(m3_s2) + SUM_W'(m2_s2) + by;
			end else begin
				sx_s3 <= SUM_W'(m0_s2) - SUM_W'(m1_s2);
				sy_s3 <= SUM_W'(m2_s2) - SUM_W'(m3_s2);
			end
			det_s3 <= SUM_W'(m4_s2) - SUM_W'(m5_s2);
		end
	end

	// stage 4: magnitudes, forward truncation and saturation
	logic [SUM_W-1:0]        mag_x, mag_y, mag_d;
	logic [SUM_W-FRAC_W-1:0] tx, ty;
	logic                    sat_x, sat_y;
	logic [COORD_W-1:0]      fx, fy;

	always_comb begin
		mag_x = sx_s3[SUM_W-1] ? SUM_W'(-sx_s3) : SUM_W'(sx_s3);
		mag_y = sy_s3[SUM_W-1] ? SUM_W'(-sy_s3) : SUM_W'(sy_s3);
		mag_d = det_s3[SUM_W-1] ? SUM_W'(-det_s3) : SUM_W'(det_s3);
		tx = mag_x[SUM_W-1:FRAC_W];
		ty = mag_y[SUM_W-1:FRAC_W];
		if (!sx_s3[SUM_W-1]) begin
			sat_x = tx > (SUM_W-FRAC_W)'(POS_MAX);
			fx    = sat_x ? POS_MAX : tx[COORD_W-1:0];
		end else begin
			sat_x = tx > (SUM_W-FRAC_W)'(NEG_MIN);
			fx    = sat_x ? NEG_MIN : COORD_W'(-tx[COORD_W-1:0]);
		end
		if (!sy_s3[SUM_W-1]) begin
			sat_y = ty > (SUM_W-FRAC_W)'(POS_MAX);
			fy    = sat_y ? POS_MAX : ty[COORD_W-1:0];
		end else begin
			sat_y = ty > (SUM_W-FRAC_W)'(NEG_MIN);
			fy    = sat_y ? NEG_MIN : COORD_W'(-ty[COORD_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.side.mode       <= mode_s3;
			out_data.side.degen      <= (det_s3 == '0);
			out_data.side.neg_a      <= sx_s3[SUM_W-1] ^ det_s3[SUM_W-1];
			out_data.side.neg_b      <= sy_s3[SUM_W-1] ^ det_s3[SUM_W-1];
			out_data.side.fwd_a      <= fx;
			out_data.side.fwd_b      <= fy;
			out_data.side.fwd_sat    <= sat_x | sat_y;
			out_data.side.fwd_inside <= inside_s3;
			out_data.num_a           <= {mag_x, {FRAC_W{1'b0}}};
			out_data.num_b           <= {mag_y, {FRAC_W{1'b0}}};
			out_data.den             <= mag_d;
		end
	end

endmodule

/* hw/rtl/atm_div.sv */
// restoring divider pipeline, one quotient bit per stage, with final result assembly
`timescale 1ns / 1ps
module atm_div import atm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_vld,
	input  atm_front_t in_data,
	output logic       out_vld,
	output atm_out_t   out_data
);

	logic                v_s   [0:QUO_W];
	atm_side_t           side_s[0:QUO_W];
	logic [SUM_W-1:0]    den_s [0:QUO_W-1];
	logic [NUM_W-1:0]    ra_s  [0:QUO_W-1];
	logic [NUM_W-1:0]    rb_s  [0:QUO_W-1];
	logic [QUO_W-1:0]    qa_s  [0:QUO_W];
	logic [QUO_W-1:0]    qb_s  [0:QUO_W];
	logic                ova_s [0:QUO_W];
	logic                ovb_s [0:QUO_W];

	// overflow check: quotient would need more than the kept bits
	logic [CMP_W-1:0] den_top;
	assign den_top = CMP_W'(in_data.den) << QUO_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_data.side;
			den_s[0]  <= in_data.den;
			ra_s[0]   <= in_data.num_a;
			rb_s[0]   <= in_data.num_b;
			qa_s[0]   <= '0;
			qb_s[0]   <= '0;
			ova_s[0]  <= CMP_W'(in_data.num_a) >= den_top;
			ovb_s[0]  <= CMP_W'(in_data.num_b) >= den_top;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QUO_W; j++) begin : g_bit
		localparam int B = QUO_W - j;
		logic [CMP_W-1:0] dsh;
		logic             ge_a, ge_b;

		assign dsh  = CMP_W'(den_s[j-1]) << B;
		assign ge_a = CMP_W'(ra_s[j-1]) >= dsh;
		assign ge_b = CMP_W'(rb_s[j-1]) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= side_s[j-1];
				ova_s[j]  <= ova_s[j-1];
				ovb_s[j]  <= ovb_s[j-1];
				qa_s[j]   <= qa_s[j-1] | (QUO_W'(ge_a) << B);
				qb_s[j]   <= qb_s[j-1] | (QUO_W'(ge_b) << B);
			end
		end

		// partial remainders are only needed up to the last quotient bit
		if (j < QUO_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[j] <= den_s[j-1];
					ra_s[j]  <= ge_a ? ra_s[j-1] - dsh[NUM_W-1:0] : ra_s[j-1];
					rb_s[j]  <= ge_b ? rb_s[j-1] - dsh[NUM_W-1:0] : rb_s[j-1];
				end
			end
		end
	end

	// signed saturation of the quotients and result selection
	atm_side_t        sd;
	logic [QUO_W-1:0] qa, qb;
	logic             sat_a, sat_b;
	logic [COORD_W-1:0] ia, ib;
	atm_out_t         res;

	always_comb begin
		sd = side_s[QUO_W];
		qa = qa_s[QUO_W];
		qb = qb_s[QUO_W];
		if (!sd.neg_a) begin
			sat_a = ova_s[QUO_W] | (qa > POS_MAX);
			ia    = sat_a ? POS_MAX : qa;
		end else begin
			sat_a = ova_s[QUO_W] | (qa > NEG_MIN);
			ia    = sat_a ? NEG_MIN : COORD_W'(-qa);
		end
		if (!sd.neg_b) begin
			sat_b = ovb_s[QUO_W] | (qb > POS_MAX);
			ib    = sat_b ? POS_MAX : qb;
		end else begin
			sat_b = ovb_s[QUO_W] | (qb > NEG_MIN);
			ib    = sat_b ? NEG_MIN : COORD_W'(-qb);
		end
		if (sd.mode == MODE_FWD) begin
			res.mapped_a         = sd.fwd_a;
			res.mapped_b         = sd.fwd_b;
			res.inside_reference = sd.fwd_inside;
			res.degenerate       = 1'b0;
			res.saturated        = sd.fwd_sat;
		end else if (sd.degen) begin
			res.mapped_a         = '0;
			res.mapped_b         = '0;
			res.inside_reference = 1'b0;
			res.degenerate       = 1'b1;
			res.saturated        = 1'b0;
		end else begin
			res.mapped_a         = ia;
			res.mapped_b         = ib;
			res.inside_reference = in_ref(ia, ib);
			res.degenerate       = 1'b0;
			res.saturated        = sat_a | sat_b;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= v_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= res;
		end
	end

endmodule

/* hw/rtl/affine_triangle_map_inverse_unit.sv */
// Pipeline: 4 front stages, 33 divider stages and 1 output register from item
// transfer to result valid; 32 divider stages each add one bit of the quotient.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: arst_n clears all valid bits and loads the unit triangle vertices.
// top level: vertex registers, pipeline control and submodule wiring
`timescale 1ns / 1ps
module affine_triangle_map_inverse_unit import atm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  atm_in_t            item,
	output logic               result_valid,
	input  logic               result_ready,
	output atm_out_t           result,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [COORD_W-1:0] cfg_data
);

	atm_vtx_t   vtx_q;
	logic       adv;
	logic       front_vld;
	atm_front_t front_data;

	// vertex registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q.v0x <= '0;
			vtx_q.v0y <= '0;
			vtx_q.v1x <= ONE_Q16;
			vtx_q.v1y <= '0;
			vtx_q.v2x <= '0;
			vtx_q.v2y <= ONE_Q16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_V0X: vtx_q.v0x <= cfg_data;
				REG_V0Y: vtx_q.v0y <= cfg_data;
				REG_V1X: vtx_q.v1x <= cfg_data;
				REG_V1Y: vtx_q.v1y <= cfg_data;
				REG_V2X: vtx_q.v2x <= cfg_data;
				REG_V2Y: vtx_q.v2y <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless a finished result is held back
	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	atm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (item_valid && adv),
		.in_item  (item),
		.vtx      (vtx_q),
		.out_vld  (front_vld),
		.out_data (front_data)
	);

	atm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (front_vld),
		.in_data  (front_data),
		.out_vld  (result_valid),
		.out_data (result)
	);

endmodule

/* hw/rtl/atm_checker.sv */
// port-level checks for the affine triangle mapping unit
`timescale 1ns / 1ps
module atm_checker import atm_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     item_ready,
	input logic     result_valid,
	input logic     result_ready,
	input atm_out_t result
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input side only stalls behind a held result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled without output backpressure");

	// degenerate triangle gives an all-zero result
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
		result.mapped_a == '0 && result.mapped_b == '0 &&
		!result.saturated && !result.inside_reference)
		else $error("degenerate result not cleared");

	// a clipped result sits at a range limit
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
		result.mapped_a == POS_MAX || result.mapped_a == NEG_MIN ||
		result.mapped_b == POS_MAX || result.mapped_b == NEG_MIN)
		else $error("saturated flag without a clipped coordinate");

endmodule

bind affine_triangle_map_inverse_unit atm_checker u_atm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
